### design/amb_pkg.sv
// amb_pkg: shared types and codes for the multicode adjacency builder.
// Used by amb_ctrl, amb_datapath and the top level; depends on nothing.
package amb_pkg;

  // Operation bit of an input beat
  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ORDER = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_WR1,
    S_WR2,
    S_FIN
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch input beat, issue first store reads
    logic look;     // latch own degree, read partner degree
    logic wr1;      // edge check, first pair of store writes
    logic wr2;      // second store writes (partner degree and entry, or a loop's second entry)
    logic push;     // commit state, load output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_edge;  // beat at the input port is an edge byte
    logic fits;     // both endpoints have room for the edge
  } stat_t;

endpackage

### design/amb_ram.sv
// amb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module amb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/amb_datapath.sv
// amb_datapath: decode registers, degree and neighbour stores, result register.
// Depends on amb_pkg and amb_ram; driven by amb_ctrl commands.
module amb_datapath #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_DEG      = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  amb_pkg::cmd_t      cmd,
  output amb_pkg::stat_t     stat,
  input  logic               op,
  input  logic [7:0]         code_byte,
  input  logic [6:0]         query_vertex,
  input  logic [2:0]         query_slot,
  output logic [1:0]         status,
  output logic [6:0]         current_vertex,
  output logic               graph_done,
  output logic [6:0]         graph_order,
  output logic [6:0]         neighbour,
  output logic [3:0]         degree
);

  localparam int VW       = $clog2(MAX_VERTICES + 1);
  localparam int DW       = $clog2(MAX_DEG + 1);
  localparam int SW       = $clog2(MAX_DEG);
  localparam int NW       = VW + SW;
  localparam int DEG_DEPTH = MAX_VERTICES + 1;
  localparam int NB_DEPTH = (MAX_VERTICES + 1) * (2 ** SW);
  localparam logic [8:0]    MV_L  = 9'(MAX_VERTICES);
  localparam logic [DW:0]   MD_W  = (DW + 1)'(MAX_DEG);
  localparam logic [DW-1:0] MD_D  = DW'(MAX_DEG);
  localparam logic [4:0]    MD_5  = 5'(MAX_DEG);

  // decode state
  logic [VW-1:0] order_reg;
  logic [VW-1:0] cursor;
  logic [VW-1:0] zeros;
  logic          in_graph;
  logic [MAX_VERTICES:0] deg_valid;

  // captured beat and per-item scratch
  logic          op_q;
  logic [7:0]    b_q;
  logic [2:0]    qs_q;
  logic          qv_bad_q;
  logic          rvalid_q;
  logic [DW-1:0] dv_q;
  logic          fits_q;

  // store ports
  logic          deg_we, deg_re, nb_we, nb_re;
  logic [VW-1:0] deg_waddr, deg_raddr;
  logic [DW-1:0] deg_wdata, deg_rdata, deg_eff;
  logic [NW-1:0] nb_waddr, nb_raddr;
  logic [VW-1:0] nb_wdata, nb_rdata;

  // input-side read address
  logic          qv_bad_in;
  logic [VW-1:0] qv_addr;
  logic [VW-1:0] b_vw;
  logic          is_loop;
  logic          fits;

  // commit values
  logic [1:0]    res_status;
  logic [VW-1:0] cursor_next, order_next, zeros_next;
  logic          in_graph_next, done, clear_deg;
  logic [VW-1:0] nb_o;
  logic [DW-1:0] deg_o;
  logic [VW:0]   z1;

  amb_ram #(.WIDTH(DW), .DEPTH(DEG_DEPTH)) u_deg_ram (
    .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .re(deg_re), .raddr(deg_raddr), .rdata(deg_rdata)
  );

  amb_ram #(.WIDTH(VW), .DEPTH(NB_DEPTH)) u_nb_ram (
    .clk(clk), .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
    .re(nb_re), .raddr(nb_raddr), .rdata(nb_rdata)
  );

  // classification of the beat at the port
  assign qv_bad_in = (query_vertex == 7'd0) || ({2'b0, query_vertex} > MV_L);
  assign qv_addr   = qv_bad_in ? '0 : VW'(query_vertex);
  assign stat.in_edge = (op == amb_pkg::OP_FEED) && in_graph && (code_byte != 8'd0)
                        && (code_byte <= 8'(order_reg));

  // degree as read, zero when not written in this graph
  assign deg_eff = rvalid_q ? deg_rdata : '0;
  assign b_vw    = VW'(b_q);
  assign is_loop = (b_q == 8'(cursor));

  // room check on the two endpoint degrees
  always_comb begin
    if (is_loop) begin
      fits = ({1'b0, dv_q} + (DW + 1)'(2)) <= MD_W;
    end else begin
      fits = (dv_q < MD_D) && (deg_eff < MD_D);
    end
  end
  assign stat.fits = fits;

  // store read ports
  assign deg_re    = cmd.capture || cmd.look;
  assign deg_raddr = cmd.capture ? ((op == amb_pkg::OP_READ) ? qv_addr : cursor) : b_vw;
  assign nb_re     = cmd.capture;
  assign nb_raddr  = {qv_addr, SW'(query_slot)};

  // store write ports: first pair in wr1, second pair (one write for a loop) in wr2
  always_comb begin
    deg_we    = 1'b0;
    deg_waddr = cursor;
    deg_wdata = dv_q + (is_loop ? DW'(2) : DW'(1));
    nb_we     = 1'b0;
    nb_waddr  = {cursor, SW'(dv_q)};
    nb_wdata  = b_vw;
    if (cmd.wr1) begin
      deg_we = fits;
      nb_we  = fits;
    end else if (cmd.wr2) begin
      nb_we    = 1'b1;
      nb_wdata = cursor;
      if (is_loop) begin
        nb_waddr = {cursor, SW'(dv_q + DW'(1))};
      end else begin
        deg_we    = 1'b1;
        deg_waddr = b_vw;
        deg_wdata = deg_eff + DW'(1);
        nb_waddr  = {b_vw, SW'(deg_eff)};
      end
    end
  end

  // result and next decode state for the current item
  assign z1 = {1'b0, zeros} + (VW + 1)'(1);
  always_comb begin
    res_status    = amb_pkg::ST_OK;
    cursor_next   = cursor;
    order_next    = order_reg;
    zeros_next    = zeros;
    in_graph_next = in_graph;
    done          = 1'b0;
    clear_deg     = 1'b0;
    nb_o          = '0;
    deg_o         = '0;
    if (op_q == amb_pkg::OP_READ) begin
      if (qv_bad_q) begin
        res_status = amb_pkg::ST_RANGE;
      end else begin
        deg_o = deg_eff;
        if (({2'b0, qs_q} < 5'(deg_eff)) && ({2'b0, qs_q} < MD_5)) begin
          nb_o = nb_rdata;
        end
      end
    end else if (!in_graph) begin
      // order byte of a new graph
      if ((b_q == 8'd0) || ({1'b0, b_q} > MV_L)) begin
        res_status = amb_pkg::ST_BAD_ORDER;
      end else begin
        order_next = b_vw;
        zeros_next = '0;
        clear_deg  = 1'b1;
        if (b_q == 8'd1) begin
          done        = 1'b1;
          cursor_next = '0;
        end else begin
          in_graph_next = 1'b1;
          cursor_next   = VW'(1);
        end
      end
    end else if (b_q == 8'd0) begin
      // separator
      zeros_next = VW'(z1);
      if ((z1 + (VW + 1)'(1)) >= {1'b0, order_reg}) begin
        done          = 1'b1;
        in_graph_next = 1'b0;
        cursor_next   = '0;
      end else begin
        cursor_next = cursor + VW'(1);
      end
    end else if (b_q > 8'(order_reg)) begin
      res_status = amb_pkg::ST_RANGE;
    end else if (!fits_q) begin
      res_status = amb_pkg::ST_OVERFLOW;
    end
  end

  // decode state and degree valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      order_reg <= '0;
      cursor    <= '0;
      zeros     <= '0;
      in_graph  <= 1'b0;
      deg_valid <= '0;
    end else begin
      if (cmd.push) begin
        order_reg <= order_next;
        cursor    <= cursor_next;
        zeros     <= zeros_next;
        in_graph  <= in_graph_next;
      end
      if (clear_deg && cmd.push) begin
        deg_valid <= '0;
      end else if (deg_we) begin
        deg_valid[deg_waddr] <= 1'b1;
      end
    end
  end

  // item scratch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= op;
      b_q      <= code_byte;
      qs_q     <= query_slot;
      qv_bad_q <= qv_bad_in;
    end
    if (deg_re) begin
      rvalid_q <= deg_valid[deg_raddr];
    end
    if (cmd.look) begin
      dv_q <= deg_eff;
    end
    if (cmd.wr1) begin
      fits_q <= fits;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      status         <= res_status;
      current_vertex <= 7'(cursor_next);
      graph_done     <= done;
      graph_order    <= 7'(order_next);
      neighbour      <= 7'(nb_o);
      degree         <= 4'(deg_o);
    end
  end

endmodule

### design/amb_ctrl.sv
// amb_ctrl: sequencing state machine and output valid for the builder.
// Depends on amb_pkg; commands amb_datapath.
module amb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  amb_pkg::stat_t stat,
  output amb_pkg::cmd_t  cmd
);

  amb_pkg::state_t state, state_next;
  logic            out_free;
  logic            out_valid_next;

  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      amb_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = stat.in_edge ? amb_pkg::S_LOOK : amb_pkg::S_FIN;
        end
      end
      amb_pkg::S_LOOK: state_next = amb_pkg::S_WR1;
      amb_pkg::S_WR1:  state_next = stat.fits ? amb_pkg::S_WR2 : amb_pkg::S_FIN;
      amb_pkg::S_WR2:  state_next = amb_pkg::S_FIN;
      amb_pkg::S_FIN: begin
        if (out_free) begin
          state_next = amb_pkg::S_IDLE;
        end
      end
      default: state_next = amb_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      amb_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      amb_pkg::S_LOOK: cmd.look = 1'b1;
      amb_pkg::S_WR1:  cmd.wr1  = 1'b1;
      amb_pkg::S_WR2:  cmd.wr2  = 1'b1;
      amb_pkg::S_FIN:  cmd.push = out_free;
      default: cmd = '0;
    endcase
  end

  // output beat held until taken
  assign out_valid_next = cmd.push ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= amb_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.look, cmd.wr1, cmd.wr2, cmd.push}))
    else $error("amb_ctrl: overlapping commands");

  // a result never overwrites one still waiting
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!out_valid || out_ready))
    else $error("amb_ctrl: push into full output register");

  // a pushed result is offered next cycle
  a_push_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> out_valid)
    else $error("amb_ctrl: pushed result not offered");

  // edge beats go through the degree lookup
  a_edge_look: assert property (@(posedge clk) disable iff (rst)
    (cmd.capture && stat.in_edge) |=> cmd.look)
    else $error("amb_ctrl: edge beat skipped lookup");

  // second write pair only follows a passing first
  a_wr2_order: assert property (@(posedge clk) disable iff (rst)
    cmd.wr2 |-> ($past(cmd.wr1) && $past(stat.fits)))
    else $error("amb_ctrl: second write without passing check");

endmodule

### design/multicode_adjacency_builder.sv
// multicode_adjacency_builder: top level, multicode byte decoder into adjacency stores.
// Depends on amb_pkg, amb_ctrl, amb_datapath (which holds two amb_ram stores).
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------------
//   in      | in_valid / in_ready  | op, code_byte, query_vertex, query_slot
//   out     | out_valid / out_ready| status, current_vertex, graph_done, graph_order,
//           |                      | neighbour, degree
//
// Reads, order bytes, separators and rejected bytes go from S_IDLE to S_FIN.
// An edge byte goes S_IDLE, S_LOOK, S_WR1, S_FIN when rejected for lack of room
// and also through S_WR2 when added: the degree store has one read port (own,
// then partner degree) and the neighbour store one write port (one entry per cycle).
// Reset clears decode state and the degree valid bits at once; no clearing pass.
// A finished result waits in the output register while the next beat is taken;
// that beat's final cycle holds until the register is free.
module multicode_adjacency_builder #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_DEG      = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] code_byte,
  input  logic [6:0] query_vertex,
  input  logic [2:0] query_slot,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [6:0] current_vertex,
  output logic       graph_done,
  output logic [6:0] graph_order,
  output logic [6:0] neighbour,
  output logic [3:0] degree
);

  amb_pkg::cmd_t  cmd;
  amb_pkg::stat_t stat;

  // sequencing
  amb_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  // stores and result register
  amb_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_DEG(MAX_DEG)) u_dp (
    .clk(clk), .rst(rst),
    .cmd(cmd), .stat(stat),
    .op(op), .code_byte(code_byte),
    .query_vertex(query_vertex), .query_slot(query_slot),
    .status(status), .current_vertex(current_vertex),
    .graph_done(graph_done), .graph_order(graph_order),
    .neighbour(neighbour), .degree(degree)
  );

endmodule
